// ===== rtl/mcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle rasterizer package
// Shared widths, command codes and the point group record that is passed
// from the command front end to the pixel back end.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int ValW             = 10;  // center and radius width
  localparam int DecW             = 14;  // decision variable width
  localparam int CoordBitsDefault = 12;  // default pixel coordinate width
  localparam int QueueDepth       = 2;
  localparam int QueuePtrW        = $clog2(QueueDepth);
  localparam int QueueCntW        = $clog2(QueueDepth + 1);
  localparam int GroupPixels      = 8;
  localparam int PixIdxW          = $clog2(GroupPixels);
  localparam int InDataW          = ((3 * ValW + 7) / 8) * 8;

  typedef enum logic {
    OpStart   = 1'b0,
    OpAdvance = 1'b1
  } op_e;

  // One decoded command from the slave side.
  typedef struct packed {
    op_e              op;
    logic [ValW-1:0]  center_x;
    logic [ValW-1:0]  center_y;
    logic [ValW-1:0]  radius;
  } cmd_t;

  // One octant point whose eight mirrored pixels still have to be sent.
  typedef struct packed {
    logic [ValW-1:0]  center_x;
    logic [ValW-1:0]  center_y;
    logic [ValW-1:0]  off_x;
    logic [ValW-1:0]  off_y;
    logic             done;
  } group_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== rtl/midpoint_circle_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer
// Command driven circle plotter: a start request loads center and radius,
// each advance request steps one octant point; every point yields eight
// mirrored pixels on the master stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser is the opcode (0 start, 1 advance); tdata carries
//   center_x, center_y and radius. Master stream: eight pixels per request
//   that produces a group; tdata holds pixel_x and pixel_y, tlast marks the
//   eighth pixel of a point group and tuser is set on all pixels of the
//   circle's final group. A request accepted by the front end is written
//   into the group queue and then loaded into the output register, which
//   sends one pixel per cycle while the receiver does not stall. An advance
//   with no running circle produces nothing. A two-entry group queue lets
//   the front end take requests while the back end is still sending the
//   previous group.
//   Reset clears the circle state, the queue and the output valid flag; the
//   block then idles with no circle running.
//   When the receiver stalls, the held pixel stays put; once the queue is
//   full, s_axis_tready_o drops until the back end drains an entry.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit
  import mcr_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Request stream.
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // tdata: center_x [9:0], center_y [19:10], radius [29:20], zero fill
  input  logic [InDataW-1:0] s_axis_tdata_i,
  // tuser: op
  input  logic               s_axis_tuser_i,
  // Pixel stream.
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  // tdata: pixel_x [COORD_BITS-1:0], pixel_y above it, zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata_o,
  // tlast: last_pixel
  output logic                                     m_axis_tlast_o,
  // tuser: circle_done
  output logic                                     m_axis_tuser_o
);

  localparam int OutDataW = ((2 * COORD_BITS + 7) / 8) * 8;

  cmd_t                  cmd;
  group_t                push_group, head;
  queue_stat_t           qstat;
  logic                  push, pop;
  logic [COORD_BITS-1:0] pix_x, pix_y;

  // Unpack the request; the opcode arrives on tuser.
  assign cmd.op       = op_e'(s_axis_tuser_i);
  assign cmd.center_x = s_axis_tdata_i[ValW-1:0];
  assign cmd.center_y = s_axis_tdata_i[2*ValW-1:ValW];
  assign cmd.radius   = s_axis_tdata_i[3*ValW-1:2*ValW];

  // Front end: holds the circle and steps the midpoint decision.
  mcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (s_axis_tvalid_i),
    .cmd_ready_o  (s_axis_tready_o),
    .cmd_i        (cmd),
    .queue_full_i (qstat.full),
    .push_o       (push),
    .push_group_o (push_group)
  );

  // Point groups waiting to be rasterized.
  mcr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (qstat)
  );

  // Back end: sends the eight mirrored pixels of the queue head.
  mcr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!qstat.empty),
    .pop_o        (pop),
    .pix_valid_o  (m_axis_tvalid_o),
    .pix_ready_i  (m_axis_tready_i),
    .pix_x_o      (pix_x),
    .pix_y_o      (pix_y),
    .pix_last_o   (m_axis_tlast_o),
    .pix_done_o   (m_axis_tuser_o)
  );

  // Pack the two coordinates, zero filled to whole bytes.
  assign m_axis_tdata_o = OutDataW'({pix_y, pix_x});

endmodule

// ===== rtl/mcr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle rasterizer command front end
// Holds the running circle and steps the midpoint decision on each advance
// while a circle runs, handing every new point to the group queue.
// ----------------------------------------------------------------------------
module mcr_front
  import mcr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cmd_valid_i,
  output logic   cmd_ready_o,
  input  cmd_t   cmd_i,
  input  logic   queue_full_i,
  output logic   push_o,
  output group_t push_group_o
);

  logic [ValW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [ValW-1:0] x_q, x_d, y_q, y_d;
  logic [DecW-1:0] dec_q, dec_d;
  logic            active_q, active_d;

  logic            accept;
  logic [ValW-1:0] x_inc, y_dec;
  logic [DecW-1:0] diff, step_pos, step_neg;
  logic            dec_pos;
  logic            done;

  assign cmd_ready_o = !queue_full_i;
  assign accept      = cmd_valid_i && cmd_ready_o;

  always_comb begin
    x_inc    = x_q + ValW'(1);
    y_dec    = y_q - ValW'(1);
    dec_pos  = !dec_q[DecW-1] && (dec_q != '0);
    diff     = DecW'(x_inc) - DecW'(y_dec);
    step_pos = (diff << 2) + DecW'(10);
    step_neg = (DecW'(x_inc) << 2) + DecW'(6);

    cx_d     = cx_q;
    cy_d     = cy_q;
    x_d      = x_q;
    y_d      = y_q;
    dec_d    = dec_q;
    active_d = active_q;
    push_o   = 1'b0;

    if (accept && cmd_i.op == OpStart) begin
      cx_d   = cmd_i.center_x;
      cy_d   = cmd_i.center_y;
      x_d    = '0;
      y_d    = cmd_i.radius;
      dec_d  = DecW'(3) - {{(DecW-ValW-1){1'b0}}, cmd_i.radius, 1'b0};
      push_o = 1'b1;
    end else if (accept && active_q) begin
      x_d = x_inc;
      if (dec_pos) begin
        y_d   = y_dec;
        dec_d = dec_q + step_pos;
      end else begin
        dec_d = dec_q + step_neg;
      end
      push_o = 1'b1;
    end

    done = !(x_d < y_d);
    if (push_o) begin
      active_d = !done;
    end

    push_group_o.center_x = cx_d;
    push_group_o.center_y = cy_d;
    push_group_o.off_x    = x_d;
    push_group_o.off_y    = y_d;
    push_group_o.done     = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      dec_q    <= '0;
      active_q <= 1'b0;
    end else begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      x_q      <= x_d;
      y_q      <= y_d;
      dec_q    <= dec_d;
      active_q <= active_d;
    end
  end

endmodule

// ===== rtl/mcr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle rasterizer group queue
// Short first-in first-out buffer of point groups between front and back end.
// ----------------------------------------------------------------------------
module mcr_queue
  import mcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  group_t      push_group_i,
  input  logic        pop_i,
  output group_t      head_o,
  output queue_stat_t stat_o
);

  group_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign stat_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [QueuePtrW-1:0] ptr_next(logic [QueuePtrW-1:0] p);
    logic [QueuePtrW-1:0] n;
    if (p == QueuePtrW'(QueueDepth - 1)) begin
      n = '0;
    end else begin
      n = p + QueuePtrW'(1);
    end
    return n;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + QueueCntW'(do_push) - QueueCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_group_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/mcr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle rasterizer pixel back end
// Walks the eight mirrored pixels of the queue head into an output register.
// ----------------------------------------------------------------------------
module mcr_back
  import mcr_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  group_t                head_i,
  input  logic                  head_valid_i,
  output logic                  pop_o,
  output logic                  pix_valid_o,
  input  logic                  pix_ready_i,
  output logic [COORD_BITS-1:0] pix_x_o,
  output logic [COORD_BITS-1:0] pix_y_o,
  output logic                  pix_last_o,
  output logic                  pix_done_o
);

  logic [PixIdxW-1:0]    idx_q, idx_d;
  logic                  vld_q, vld_d;
  logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic                  last_q, last_d, done_q, done_d;
  logic                  load;
  logic [ValW-1:0]       dx, dy;

  assign load  = head_valid_i && (!vld_q || pix_ready_i);
  assign pop_o = load && (idx_q == PixIdxW'(GroupPixels - 1));

  always_comb begin
    // Upper four pixels swap the roles of the two offsets.
    dx = idx_q[2] ? head_i.off_y : head_i.off_x;
    dy = idx_q[2] ? head_i.off_x : head_i.off_y;

    px_d = idx_q[0] ? COORD_BITS'(head_i.center_x) - COORD_BITS'(dx)
                    : COORD_BITS'(head_i.center_x) + COORD_BITS'(dx);
    py_d = idx_q[1] ? COORD_BITS'(head_i.center_y) - COORD_BITS'(dy)
                    : COORD_BITS'(head_i.center_y) + COORD_BITS'(dy);
    last_d = (idx_q == PixIdxW'(GroupPixels - 1));
    done_d = head_i.done;

    if (load) begin
      vld_d = 1'b1;
      idx_d = idx_q + PixIdxW'(1);
    end else begin
      vld_d = vld_q && !pix_ready_i;
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= px_d;
      py_q   <= py_d;
      last_q <= last_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  assign pix_valid_o = vld_q;
  assign pix_x_o     = px_q;
  assign pix_y_o     = py_q;
  assign pix_last_o  = last_q;
  assign pix_done_o  = done_q;

endmodule
